### rtl/ppp_pkg.sv
`default_nettype none
package ppp_pkg;

  localparam int COORD_BITS  = 32;
  localparam int COEF_BITS   = 32;
  localparam int SCREEN_BITS = 16;

  localparam int PT_W      = 32;
  localparam int OUT_W     = 32;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;
  localparam int HALF_W    = 32;
  localparam int SCR_W     = 32;

  localparam int XV_W      = (COORD_BITS > PT_W) ? PT_W + 1 : COORD_BITS;
  localparam int PROD_W    = XV_W + COEF_BITS;
  localparam int FRAC_DROP = 12;
  localparam int MAG_W     = PROD_W - FRAC_DROP - 1;
  localparam int CLAMP_LOG = 60;
  localparam int TERM_W    = (MAG_W > CLAMP_LOG) ? CLAMP_LOG + 1 : MAG_W;
  localparam int CMP_W     = (MAG_W > CLAMP_LOG) ? MAG_W : CLAMP_LOG + 1;
  localparam int ADD_W     = (TERM_W + 1 > COEF_BITS) ? TERM_W + 1 : COEF_BITS;
  localparam int C_W       = ADD_W + 2;

  localparam int HALF_SHIFT = 7;
  localparam int CL_W       = C_W / 2;
  localparam int CH_W       = C_W - CL_W;
  localparam int NP_W       = C_W + SCREEN_BITS;
  localparam int N_W        = NP_W + HALF_SHIFT;
  localparam int QUOT_LOG   = 40;
  localparam int Q_N        = QUOT_LOG + 1;
  localparam int NX_W       = (N_W > Q_N) ? N_W : Q_N + 1;
  localparam int HI_W       = NX_W - Q_N;
  localparam int TOPCMP_W   = (HI_W > C_W) ? HI_W : C_W;
  localparam int PX_W       = QUOT_LOG + 3;

  localparam int W_MIN = 66;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_FIRST,
    REG_X_SECOND,
    REG_Y_FIRST,
    REG_Y_SECOND,
    REG_W_FIRST,
    REG_W_SECOND,
    REG_SCREEN
  } reg_idx_t;

  // One beat travelling along the divider chain, both lanes side by side.
  typedef struct packed {
    logic                   valid;
    logic                   behind;
    logic                   neg_x;
    logic                   neg_y;
    logic                   ovf_x;
    logic                   ovf_y;
    logic [C_W-1:0]         rem_x;
    logic [C_W-1:0]         rem_y;
    logic [Q_N-1:0]         num_x;
    logic [Q_N-1:0]         num_y;
    logic [Q_N-1:0]         quo_x;
    logic [Q_N-1:0]         quo_y;
    logic [C_W-1:0]         w;
    logic [SCREEN_BITS-1:0] wd;
    logic [SCREEN_BITS-1:0] ht;
  } cell_t;

endpackage
`default_nettype wire

### rtl/ppp_point_if.sv
`default_nettype none
interface ppp_point_if import ppp_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [PT_W-1:0] point_x;
  logic signed [PT_W-1:0] point_y;
  logic signed [PT_W-1:0] point_z;

  modport source (output valid, output point_x, output point_y, output point_z,
                  input ready);
  modport sink   (input valid, input point_x, input point_y, input point_z,
                  output ready);
endinterface
`default_nettype wire

### rtl/ppp_pixel_if.sv
`default_nettype none
interface ppp_pixel_if import ppp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] pixel_x;
  logic signed [OUT_W-1:0] pixel_y;
  logic                    on_screen;

  modport source (output valid, output pixel_x, output pixel_y, output on_screen,
                  input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input on_screen,
                  output ready);
endinterface
`default_nettype wire

### rtl/perspective_point_projector.sv
`default_nettype none
// Perspective point projector. Each beat on point_ch carries one world point in
// signed Q20.12; the block multiplies it by the X, Y and W rows of the view-projection
// matrix held in the configuration registers, and each beat on pixel_ch returns the
// screen position in signed Q24.8 with an on-screen flag. Points with clip w below
// 0.001 are reported as behind the camera, with every field 0. One point is accepted
// every cycle while the output is not held, and the results come out in order after
// the row multiply and sum, the numerator product, the 41-cell divider chain with
// one quotient bit per cell, and the output register. Both sides stall together
// when the output beat is not taken. The configuration registers must only be
// written while no point is in flight.
module perspective_point_projector import ppp_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  ppp_point_if.sink                 point_ch,
  ppp_pixel_if.source               pixel_ch
);

  // Configuration registers; a write to an index beyond the list is dropped.
  logic [CFG_W-1:0] row_x_first, row_x_second;
  logic [CFG_W-1:0] row_y_first, row_y_second;
  logic [CFG_W-1:0] row_w_first, row_w_second;
  logic [SCR_W-1:0] screen_dims;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_x_first  <= '0;
      row_x_second <= '0;
      row_y_first  <= '0;
      row_y_second <= '0;
      row_w_first  <= '0;
      row_w_second <= '0;
      screen_dims  <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_X_FIRST:  row_x_first  <= cfg_data;
        REG_X_SECOND: row_x_second <= cfg_data;
        REG_Y_FIRST:  row_y_first  <= cfg_data;
        REG_Y_SECOND: row_y_second <= cfg_data;
        REG_W_FIRST:  row_w_first  <= cfg_data;
        REG_W_SECOND: row_w_second <= cfg_data;
        REG_SCREEN:   screen_dims  <= cfg_data[SCR_W-1:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline moves as one; it holds only while an output beat waits.
  logic en;
  logic out_valid;
  assign en             = !out_valid || pixel_ch.ready;
  assign point_ch.ready = en;
  assign pixel_ch.valid = out_valid;

  // Coordinates are taken from their low COORD_BITS bits with sign extension.
  logic signed [XV_W-1:0] vx, vy, vz;
  if (COORD_BITS > PT_W) begin : g_coord_wide
    assign vx = $signed({1'b0, point_ch.point_x});
    assign vy = $signed({1'b0, point_ch.point_y});
    assign vz = $signed({1'b0, point_ch.point_z});
  end else begin : g_coord_narrow
    assign vx = $signed(point_ch.point_x[COORD_BITS-1:0]);
    assign vy = $signed(point_ch.point_y[COORD_BITS-1:0]);
    assign vz = $signed(point_ch.point_z[COORD_BITS-1:0]);
  end

  logic signed [C_W-1:0] cx, cy, cw;

  ppp_row u_row_x (
    .clk (clk), .en (en), .x (vx), .y (vy), .z (vz),
    .k0  ($signed(row_x_first[COEF_BITS-1:0])),
    .k1  ($signed(row_x_first[HALF_W+COEF_BITS-1:HALF_W])),
    .k2  ($signed(row_x_second[COEF_BITS-1:0])),
    .t   ($signed(row_x_second[HALF_W+COEF_BITS-1:HALF_W])),
    .c   (cx)
  );

  ppp_row u_row_y (
    .clk (clk), .en (en), .x (vx), .y (vy), .z (vz),
    .k0  ($signed(row_y_first[COEF_BITS-1:0])),
    .k1  ($signed(row_y_first[HALF_W+COEF_BITS-1:HALF_W])),
    .k2  ($signed(row_y_second[COEF_BITS-1:0])),
    .t   ($signed(row_y_second[HALF_W+COEF_BITS-1:HALF_W])),
    .c   (cy)
  );

  ppp_row u_row_w (
    .clk (clk), .en (en), .x (vx), .y (vy), .z (vz),
    .k0  ($signed(row_w_first[COEF_BITS-1:0])),
    .k1  ($signed(row_w_first[HALF_W+COEF_BITS-1:HALF_W])),
    .k2  ($signed(row_w_second[COEF_BITS-1:0])),
    .t   ($signed(row_w_second[HALF_W+COEF_BITS-1:HALF_W])),
    .c   (cw)
  );

  // Valid bits alongside the two row-unit register stages and numerator stage one.
  logic v1, v2, v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= point_ch.valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Numerator stage one: the magnitude of each clip coordinate is multiplied by
  // its window dimension in two halves, so that no single product grows too wide.
  logic [SCREEN_BITS-1:0] wd_m, ht_m;
  logic [C_W-1:0]         cxm, cym;
  assign wd_m = screen_dims[SCREEN_BITS-1:0];
  assign ht_m = screen_dims[SCR_W/2+SCREEN_BITS-1:SCR_W/2];
  assign cxm  = cx[C_W-1] ? $unsigned(-cx) : $unsigned(cx);
  assign cym  = cy[C_W-1] ? $unsigned(-cy) : $unsigned(cy);

  logic [CL_W+SCREEN_BITS-1:0] plx, ply;
  logic [CH_W+SCREEN_BITS-1:0] phx, phy;
  logic                        s3_behind, s3_neg_x, s3_neg_y;
  logic [C_W-1:0]              s3_w;
  logic [SCREEN_BITS-1:0]      s3_wd, s3_ht;

  always_ff @(posedge clk) begin
    if (en) begin
      plx       <= cxm[CL_W-1:0] * wd_m;
      phx       <= cxm[C_W-1:CL_W] * wd_m;
      ply       <= cym[CL_W-1:0] * ht_m;
      phy       <= cym[C_W-1:CL_W] * ht_m;
      s3_behind <= cw < $signed(C_W'(W_MIN));
      s3_neg_x  <= cx[C_W-1];
      s3_neg_y  <= cy[C_W-1];
      s3_w      <= $unsigned(cw);
      s3_wd     <= wd_m;
      s3_ht     <= ht_m;
    end
  end

  // Numerator stage two: join the halves, scale by 128 for half the dimension in
  // Q.8, and test whether the quotient already reaches 2^41 before the chain starts.
  logic [NP_W-1:0]     npx, npy;
  logic [NX_W-1:0]     nnx, nny;
  logic [TOPCMP_W-1:0] topx, topy, wext;

  always_comb begin
    npx  = (NP_W'(phx) << CL_W) + NP_W'(plx);
    npy  = (NP_W'(phy) << CL_W) + NP_W'(ply);
    nnx  = NX_W'(npx) << HALF_SHIFT;
    nny  = NX_W'(npy) << HALF_SHIFT;
    topx = TOPCMP_W'(nnx[NX_W-1:Q_N]);
    topy = TOPCMP_W'(nny[NX_W-1:Q_N]);
    wext = TOPCMP_W'(s3_w);
  end

  cell_t chain [Q_N+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].valid <= 1'b0;
    end else if (en) begin
      chain[0].valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      chain[0].behind <= s3_behind;
      chain[0].neg_x  <= s3_neg_x;
      chain[0].neg_y  <= s3_neg_y;
      chain[0].ovf_x  <= topx >= wext;
      chain[0].ovf_y  <= topy >= wext;
      chain[0].rem_x  <= topx[C_W-1:0];
      chain[0].rem_y  <= topy[C_W-1:0];
      chain[0].num_x  <= nnx[Q_N-1:0];
      chain[0].num_y  <= nny[Q_N-1:0];
      chain[0].quo_x  <= '0;
      chain[0].quo_y  <= '0;
      chain[0].w      <= s3_w;
      chain[0].wd     <= s3_wd;
      chain[0].ht     <= s3_ht;
    end
  end

  // The divider proper: one quotient bit per cell, both lanes sharing the divisor.
  for (genvar i = 0; i < Q_N; i++) begin : g_cells
    ppp_div_cell u_cell (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .d   (chain[i]),
      .q   (chain[i+1])
    );
  end

  // Finishing: clamp the quotient to 2^40, restore the sign, offset to the window
  // centre (y inverted), test the bounds on the full value, then saturate.
  localparam logic signed [PX_W-1:0] SAT_HI = PX_W'(64'sd2147483647);
  localparam logic signed [PX_W-1:0] SAT_LO = -SAT_HI - PX_W'(1);

  cell_t                  last;
  logic [Q_N-1:0]         mx, my;
  logic signed [PX_W-1:0] sx, sy, px, py, hx, hy, fx, fy;
  logic [OUT_W-1:0]       ox, oy;
  logic                   vis;

  always_comb begin
    last = chain[Q_N];
    mx = (last.ovf_x || last.quo_x > (Q_N'(1) << QUOT_LOG)) ? Q_N'(1) << QUOT_LOG
                                                             : last.quo_x;
    my = (last.ovf_y || last.quo_y > (Q_N'(1) << QUOT_LOG)) ? Q_N'(1) << QUOT_LOG
                                                             : last.quo_y;
    sx = last.neg_x ? -$signed(PX_W'(mx)) : $signed(PX_W'(mx));
    sy = last.neg_y ? -$signed(PX_W'(my)) : $signed(PX_W'(my));
    hx = $signed(PX_W'({last.wd, 7'b0}));
    hy = $signed(PX_W'({last.ht, 7'b0}));
    fx = $signed(PX_W'({last.wd, 8'b0}));
    fy = $signed(PX_W'({last.ht, 8'b0}));
    px = hx + sx;
    py = hy - sy;
    vis = !px[PX_W-1] && (px <= fx) && !py[PX_W-1] && (py <= fy);
    ox = (px > SAT_HI) ? OUT_W'(SAT_HI) : (px < SAT_LO) ? OUT_W'(SAT_LO) : px[OUT_W-1:0];
    oy = (py > SAT_HI) ? OUT_W'(SAT_HI) : (py < SAT_LO) ? OUT_W'(SAT_LO) : py[OUT_W-1:0];
    if (last.behind) begin
      ox  = '0;
      oy  = '0;
      vis = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pixel_ch.pixel_x   <= $signed(ox);
      pixel_ch.pixel_y   <= $signed(oy);
      pixel_ch.on_screen <= vis;
    end
  end

`ifndef SYNTH
  // An accepted point must always enter the first stage.
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (point_ch.valid && point_ch.ready) |=> v1)
    else $error("accepted point did not enter the pipeline");

  // A point reported on screen has non-negative coordinates on both axes.
  a_visible_nonneg: assert property (@(posedge clk) disable iff (rst)
    (pixel_ch.valid && pixel_ch.on_screen) |-> (!pixel_ch.pixel_x[OUT_W-1] &&
                                                !pixel_ch.pixel_y[OUT_W-1]))
    else $error("on-screen beat with a negative pixel coordinate");
`endif

endmodule
`default_nettype wire

### rtl/ppp_row.sv
`default_nettype none
module ppp_row import ppp_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic signed [XV_W-1:0]  x,
  input  wire logic signed [XV_W-1:0]  y,
  input  wire logic signed [XV_W-1:0]  z,
  input  wire logic signed [COEF_BITS-1:0] k0,
  input  wire logic signed [COEF_BITS-1:0] k1,
  input  wire logic signed [COEF_BITS-1:0] k2,
  input  wire logic signed [COEF_BITS-1:0] t,
  output logic signed [C_W-1:0]        c
);

  logic signed [PROD_W-1:0]    p0, p1, p2;
  logic signed [COEF_BITS-1:0] t_d;

  // Magnitude truncated towards zero to Q.16, clamped, sign restored.
  function automatic logic signed [TERM_W:0] trunc_term(input logic signed [PROD_W-1:0] p);
    logic [PROD_W-1:0] m;
    logic [MAG_W-1:0]  ms;
    logic [CMP_W-1:0]  me;
    logic [TERM_W-1:0] mt;
    m  = p[PROD_W-1] ? $unsigned(-p) : $unsigned(p);
    ms = m[PROD_W-2:FRAC_DROP];
    me = CMP_W'(ms);
    mt = (me > (CMP_W'(1) << CLAMP_LOG)) ? TERM_W'(CMP_W'(1) << CLAMP_LOG) : TERM_W'(ms);
    return p[PROD_W-1] ? -$signed({1'b0, mt}) : $signed({1'b0, mt});
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      p0  <= x * k0;
      p1  <= y * k1;
      p2  <= z * k2;
      t_d <= t;
      c   <= C_W'(trunc_term(p0)) + C_W'(trunc_term(p1)) + C_W'(trunc_term(p2))
             + C_W'(t_d);
    end
  end

endmodule
`default_nettype wire

### rtl/ppp_div_cell.sv
`default_nettype none
module ppp_div_cell import ppp_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  en,
  input  wire cell_t d,
  output cell_t      q
);

  // One restoring step: bring down the next numerator bit, subtract if it fits.
  function automatic logic [C_W:0] div_step(input logic [C_W-1:0] r, input logic nb,
                                             input logic [C_W-1:0] w);
    logic [C_W:0] tr;
    logic [C_W:0] we;
    logic         ge;
    tr = {r, nb};
    we = {1'b0, w};
    ge = tr >= we;
    return {ge, ge ? C_W'(tr - we) : C_W'(tr)};
  endfunction

  logic [C_W:0] sx, sy;

  always_comb begin
    sx = div_step(d.rem_x, d.num_x[Q_N-1], d.w);
    sy = div_step(d.rem_y, d.num_y[Q_N-1], d.w);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q.valid <= d.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q.behind <= d.behind;
      q.neg_x  <= d.neg_x;
      q.neg_y  <= d.neg_y;
      q.ovf_x  <= d.ovf_x;
      q.ovf_y  <= d.ovf_y;
      q.rem_x  <= sx[C_W-1:0];
      q.rem_y  <= sy[C_W-1:0];
      q.num_x  <= d.num_x << 1;
      q.num_y  <= d.num_y << 1;
      q.quo_x  <= {d.quo_x[Q_N-2:0], sx[C_W]};
      q.quo_y  <= {d.quo_y[Q_N-2:0], sy[C_W]};
      q.w      <= d.w;
      q.wd     <= d.wd;
      q.ht     <= d.ht;
    end
  end

endmodule
`default_nettype wire

### dv/perspective_point_projector_test.sv
`default_nettype none
module perspective_point_projector_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ppp_pkg::*;

  // Register index that lies beyond the register file; a write to it must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  // Cycles without any beat on either side before the run is given up.
  localparam int STALL_LIMIT = 2000;
  // Margin the drain waits once every expected pixel has come back.
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES = 300;
  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

  typedef struct {
    logic signed [OUT_W-1:0] px;
    logic signed [OUT_W-1:0] py;
    logic                    on;
  } pixel_beat_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  ppp_point_if point_bus ();
  ppp_pixel_if pixel_bus ();

  perspective_point_projector i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .point_ch (point_bus.sink),
    .pixel_ch (pixel_bus.source)
  );

  // The testbench's own copy of the register file, and the pixels still owed by the block.
  logic [CFG_W-1:0] matrix_regs [REG_SCREEN+1];
  pixel_beat_t pending_pixels [$];
  int errors = 0;
  bit gaps_on = 1'b0;
  bit stalls_on = 1'b0;
  bit hold_request = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Each product of a Q20.12 coordinate and a Q16.16 coefficient is kept exact, then its
  // magnitude is cut back to Q.16 by truncation and clamped to 2^60 before the sign returns.
  function automatic longint scaled_product(longint coord, longint coef);
    logic [127:0] prod;
    logic [63:0] mc, mk;
    mc = (coord < 0) ? -coord : coord;
    mk = (coef < 0) ? -coef : coef;
    prod = {64'd0, mc} * {64'd0, mk};
    prod = prod >> 12;
    if (prod > (128'd1 << 60)) prod = 128'd1 << 60;
    return ((coord < 0) != (coef < 0)) ? -longint'(prod[63:0]) : longint'(prod[63:0]);
  endfunction

  function automatic longint clip_coord(logic [63:0] first, logic [63:0] second,
                                        longint px, longint py, longint pz);
    return scaled_product(px, longint'($signed(first[31:0])))
         + scaled_product(py, longint'($signed(first[63:32])))
         + scaled_product(pz, longint'($signed(second[31:0])))
         + longint'($signed(second[63:32]));
  endfunction

  // Signed c * dim * 128 / w, with the quotient magnitude truncated and clamped to 2^40.
  function automatic longint half_screen_offset(longint c, logic [SCREEN_BITS-1:0] dim,
                                                longint w);
    logic [127:0] num, quot;
    logic [63:0] mc;
    mc = (c < 0) ? -c : c;
    num = {64'd0, mc} * ({112'd0, dim} << 7);
    quot = num / {64'd0, w};
    if (quot > (128'd1 << 40)) quot = 128'd1 << 40;
    return (c < 0) ? -longint'(quot[63:0]) : longint'(quot[63:0]);
  endfunction

  function automatic logic [OUT_W-1:0] clamp_to_pixel(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic pixel_beat_t project_point(logic [PT_W-1:0] x, logic [PT_W-1:0] y,
                                                logic [PT_W-1:0] z);
    pixel_beat_t res;
    longint px, py, pz, cx, cy, cw, sx, sy;
    logic [SCREEN_BITS-1:0] wd, ht;
    px = longint'($signed(x));
    py = longint'($signed(y));
    pz = longint'($signed(z));
    wd = matrix_regs[REG_SCREEN][15:0];
    ht = matrix_regs[REG_SCREEN][31:16];
    cw = clip_coord(matrix_regs[REG_W_FIRST], matrix_regs[REG_W_SECOND], px, py, pz);
    res = '{px: '0, py: '0, on: 1'b0};
    // Behind the camera every field reads zero.
    if (cw < W_MIN) return res;
    cx = clip_coord(matrix_regs[REG_X_FIRST], matrix_regs[REG_X_SECOND], px, py, pz);
    cy = clip_coord(matrix_regs[REG_Y_FIRST], matrix_regs[REG_Y_SECOND], px, py, pz);
    // The y axis is inverted: screen rows grow downwards.
    sx = longint'(wd) * 128 + half_screen_offset(cx, wd, cw);
    sy = longint'(ht) * 128 - half_screen_offset(cy, ht, cw);
    res.px = clamp_to_pixel(sx);
    res.py = clamp_to_pixel(sy);
    // The window test sees the value before saturation; a zero-sized axis admits only 0.
    res.on = (sx >= 0) && (sx <= longint'(wd) * 256) && (sy >= 0) && (sy <= longint'(ht) * 256);
    return res;
  endfunction

  // Writes every register in turn, then the unused index, which the block must ignore.
  task automatic load_matrix(input logic [CFG_W-1:0] vals [REG_SCREEN+1]);
    for (int i = 0; i <= REG_SCREEN; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= i[CFG_IDX_W-1:0];
      cfg_data <= vals[i];
      matrix_regs[i] = (i == REG_SCREEN) ? {32'd0, vals[i][31:0]} : vals[i];
      @(posedge clk);
    end
    cfg_index <= REG_UNUSED;
    cfg_data <= {$urandom, $urandom};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Offers one point and holds it until the block takes it; the expected pixel is
  // queued on the edge of acceptance. Valid is left high for a following beat.
  task automatic send_point(input logic [PT_W-1:0] x, input logic [PT_W-1:0] y,
                            input logic [PT_W-1:0] z);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      point_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    point_bus.valid <= 1'b1;
    point_bus.point_x <= x;
    point_bus.point_y <= y;
    point_bus.point_z <= z;
    do @(posedge clk); while (!point_bus.ready);
    pending_pixels.push_back(project_point(x, y, z));
  endtask

  // Lets the pipeline run dry so that registers may be written safely.
  task automatic drain_pipeline();
    point_bus.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] random_coef(int spread_log);
    if ($urandom_range(0, 9) == 0) return $urandom;
    return 32'($signed(longint'($urandom_range(0, 2 ** (spread_log + 1))) - 2 ** spread_log));
  endfunction

  // A plausible camera: small X and Y rows and a W row dominated by z, so that points
  // fall in front, behind and across the window edges in useful proportions.
  task automatic load_random_camera();
    logic [CFG_W-1:0] vals [REG_SCREEN+1];
    vals[REG_X_FIRST] = {random_coef(18), random_coef(18)};
    vals[REG_X_SECOND] = {random_coef(20), random_coef(18)};
    vals[REG_Y_FIRST] = {random_coef(18), random_coef(18)};
    vals[REG_Y_SECOND] = {random_coef(20), random_coef(18)};
    vals[REG_W_FIRST] = {random_coef(14), random_coef(14)};
    vals[REG_W_SECOND] = {random_coef(16), ONE_Q16 + random_coef(14)};
    if ($urandom_range(0, 4) == 0) vals[REG_SCREEN] = {$urandom, $urandom};
    else vals[REG_SCREEN] = {32'd0, 16'($urandom_range(0, 2048)), 16'($urandom_range(0, 2048))};
    load_matrix(vals);
  endtask

  // Mostly points within a few hundred units of the origin; now and then raw noise so
  // that every coordinate bit toggles.
  task automatic send_random_point();
    if ($urandom_range(0, 7) == 0) send_point($urandom, $urandom, $urandom);
    else send_point(32'($signed(longint'($urandom_range(0, 2 ** 22)) - 2 ** 21)),
                    32'($signed(longint'($urandom_range(0, 2 ** 22)) - 2 ** 21)),
                    32'($signed(longint'($urandom_range(0, 2 ** 22 + 2 ** 18)) - 2 ** 18)));
  endtask

  // A simple camera looking down z, so w equals z, in a 640 by 480 window. Covers the
  // centre, the window corners and the coordinate extremes.
  task automatic test_simple_camera();
    logic [CFG_W-1:0] vals [REG_SCREEN+1];
    vals = '{{32'd0, ONE_Q16}, 64'd0, {ONE_Q16, 32'd0}, 64'd0, 64'd0, {32'd0, ONE_Q16},
             {32'd0, 16'd480, 16'd640}};
    load_matrix(vals);
    send_point(32'd0, 32'd0, 32'd4096);
    send_point(32'hFFFF_F000, 32'h0000_1000, 32'd4096);
    send_point(32'h0000_1000, 32'hFFFF_F000, 32'd4096);
    send_point(32'h0000_1001, 32'd0, 32'd4096);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0010);
    send_point(32'd0, 32'd0, 32'h8000_0000);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1);
    send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain_pipeline();
  endtask

  // Clip w set by the translation term alone: exactly at the camera threshold and one
  // step below it, where the point counts as behind the camera.
  task automatic test_w_threshold();
    logic [CFG_W-1:0] vals [REG_SCREEN+1];
    vals = '{{32'd0, 32'h7FFF_FFFF}, 64'd0, {32'h8000_0000, 32'd0}, 64'd0, 64'd0,
             {32'd66, 32'd0}, {32'd0, 16'hFFFF, 16'hFFFF}};
    load_matrix(vals);
    send_point(32'd0, 32'd0, 32'd0);
    send_point(32'd1, 32'd1, 32'd0);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0);
    vals[REG_W_SECOND] = {32'd65, 32'd0};
    drain_pipeline();
    load_matrix(vals);
    send_point(32'd0, 32'd0, 32'd0);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    drain_pipeline();
  endtask

  // Extreme coefficients in all but the first W register drive the quotient clamp
  // and the 32-bit saturation of the pixels.
  task automatic test_saturation();
    logic [CFG_W-1:0] vals [REG_SCREEN+1];
    vals = '{{32'h8000_0000, 32'h7FFF_FFFF}, {32'h7FFF_FFFF, 32'h8000_0000},
             {32'h7FFF_FFFF, 32'h8000_0000}, {32'h8000_0000, 32'h7FFF_FFFF},
             {32'h0000_0001, 32'h0000_0001}, {32'h7FFF_FFFF, 32'h7FFF_FFFF},
             {32'hFFFF_FFFF, 32'hFFFF_FFFF}};
    load_matrix(vals);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
    send_point(32'd0, 32'd0, 32'd0);
    drain_pipeline();
  endtask

  // A window of zero size: only a pixel at exactly 0 along that axis counts as visible.
  task automatic test_zero_window();
    logic [CFG_W-1:0] vals [REG_SCREEN+1];
    vals = '{{32'd0, ONE_Q16}, 64'd0, {ONE_Q16, 32'd0}, 64'd0, 64'd0, {32'd0, ONE_Q16},
             64'd0};
    load_matrix(vals);
    send_point(32'd0, 32'd0, 32'd4096);
    send_point(32'd4096, 32'd0, 32'd4096);
    send_point(32'd0, 32'hFFFF_F000, 32'd8192);
    drain_pipeline();
  endtask

  task automatic test_random_cameras(input int n_cameras, input int per_camera);
    for (int c = 0; c < n_cameras; c++) begin
      load_random_camera();
      repeat (per_camera) send_random_point();
      drain_pipeline();
    end
  endtask

  // The receiver holds off long enough for the pipeline to fill while points keep
  // coming, so the input has to stall.
  task automatic test_backpressure();
    load_random_camera();
    hold_request = 1'b1;
    repeat (150) send_random_point();
    drain_pipeline();
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_X_FIRST;
    cfg_data <= '0;
    point_bus.valid <= 1'b0;
    point_bus.point_x <= '0;
    point_bus.point_y <= '0;
    point_bus.point_z <= '0;
    for (int i = 0; i <= REG_SCREEN; i++) matrix_regs[i] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_simple_camera();
    test_w_threshold();
    test_saturation();
    test_zero_window();
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    test_random_cameras(12, 100);
    test_backpressure();
    // The closing stretch streams at full rate on both sides.
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    test_random_cameras(2, 100);
    drain_pipeline();

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    pixel_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        pixel_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
        pixel_bus.ready <= 1'b1;
      end else if (stalls_on && $urandom_range(0, 7) == 0) begin
        pixel_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        pixel_bus.ready <= 1'b1;
      end else begin
        pixel_bus.ready <= 1'b1;
      end
    end
  end

  // Compares each pixel beat with the oldest expectation.
  always @(posedge clk) begin
    pixel_beat_t exp_pix;
    if (!rst && pixel_bus.valid && pixel_bus.ready) begin
      if (pending_pixels.size() == 0) begin
        $error("pixel beat with nothing expected");
        errors++;
      end else begin
        exp_pix = pending_pixels.pop_front();
        if (pixel_bus.pixel_x !== exp_pix.px) begin
          $error("pixel_x expected %0d got %0d", exp_pix.px, pixel_bus.pixel_x);
          errors++;
        end
        if (pixel_bus.pixel_y !== exp_pix.py) begin
          $error("pixel_y expected %0d got %0d", exp_pix.py, pixel_bus.pixel_y);
          errors++;
        end
        if (pixel_bus.on_screen !== exp_pix.on) begin
          $error("on_screen expected %0b got %0b", exp_pix.on, pixel_bus.on_screen);
          errors++;
        end
      end
    end
  end

  // Watchdog: gives up when no beat moves on either side for too long.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((point_bus.valid && point_bus.ready) || (pixel_bus.valid && pixel_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
`default_nettype wire
